// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define RTFP_ASSERT(label, clk_sig, rst_n, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) prop) \
		else $error(msg);

// Expression must never be true at a rising clock edge outside reset
`define RTFP_NEVER(label, clk_sig, rst_n, expr, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ----- design/rtfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Radar target frame parser package
// Frame markers, status and kind codes, and the shared command and result types.
// ----------------------------------------------------------------------------
package rtfp_pkg;

	localparam int POS_W = 9;
	localparam int CNT_W = 6;

	localparam logic [7:0] HEAD0 = 8'h55;
	localparam logic [7:0] HEAD1 = 8'hAA;
	localparam logic [7:0] TAIL0 = 8'h5A;
	localparam logic [7:0] TAIL1 = 8'hA5;

	localparam logic [1:0] ST_GOOD  = 2'd0;
	localparam logic [1:0] ST_CSUM  = 2'd1;
	localparam logic [1:0] ST_TAIL  = 2'd2;
	localparam logic [1:0] ST_COUNT = 2'd3;

	localparam logic KIND_TARGET  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic REG_LIMIT = 1'b0;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd32;

	// Frame layout
	localparam logic [POS_W-1:0] POS_COUNT    = 9'd5;
	localparam logic [POS_W-1:0] POS_BODY     = 9'd6;
	localparam logic [POS_W-1:0] POS_SUM0     = 9'd2;
	localparam logic [POS_W-1:0] POS_DIST     = 9'd3;
	localparam logic [POS_W-1:0] LEN_BASE     = 9'd12;
	localparam logic [POS_W-1:0] CHK_FROM_END = 9'd3;

	typedef struct packed {
		logic              go;
		logic              check;
		logic [1:0]        status;
		logic [CNT_W-1:0]  count;
		logic [POS_W-1:0]  len;
	} rtfp_cmd_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [4:0]  index;
		logic [15:0] distance;
		logic [15:0] velocity;
		logic [15:0] angle_h;
		logic [15:0] angle_v;
		logic [7:0]  snr;
		logic [15:0] nearest;
		logic [7:0]  interval;
		logic [15:0] number;
		logic        last;
	} rtfp_res_t;

endpackage

// ----- design/rtfp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rtfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/rtfp_seq.sv -----
// ----------------------------------------------------------------------------
// Frame read-back sequencer
// Walks the frame buffer one byte at a time: sums the checksum span with a
// byte adder, then gathers target records and the summary, or just a summary.
// ----------------------------------------------------------------------------
module rtfp_seq #(
	parameter int BUFFER_DEPTH = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rtfp_pkg::rtfp_cmd_t             cmd,
	output logic                            busy,
	output logic                            ram_re,
	output logic [$clog2(BUFFER_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                      ram_rdata,
	output rtfp_pkg::rtfp_res_t             res,
	output logic                            res_valid,
	input  logic                            res_ready
);

	import rtfp_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SUM    = 2'd1;
	localparam logic [1:0] S_GATHER = 2'd2;
	localparam logic [1:0] S_EMIT   = 2'd3;

	logic [1:0]       state_q;
	logic             ph_q;
	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    chk_addr_q;
	logic [7:0]       sum_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [3:0]       bc_q;
	logic [63:0]      shr_q;
	rtfp_res_t        res_q;

	logic [71:0] rec;
	logic [39:0] smry;

	function automatic rtfp_res_t mk_summary(input logic [1:0] st);
		rtfp_res_t r;
		r        = '0;
		r.kind   = KIND_SUMMARY;
		r.status = st;
		r.last   = 1'b1;
		return r;
	endfunction

	assign rec  = {shr_q, ram_rdata};
	assign smry = {shr_q[31:0], ram_rdata};

	assign busy      = (state_q != S_IDLE);
	assign ram_re    = !ph_q && ((state_q == S_SUM) || (state_q == S_GATHER));
	assign ram_raddr = addr_q;
	assign res       = res_q;
	assign res_valid = (state_q == S_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= 1'b0;
			bc_q    <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					ph_q  <= 1'b0;
					bc_q  <= '0;
					idx_q <= '0;
					if (cmd.go) begin
						state_q <= cmd.check ? S_SUM : S_EMIT;
					end
				end
				S_SUM: begin
					ph_q <= ~ph_q;
					if (ph_q && (addr_q == chk_addr_q)) begin
						state_q <= (sum_q == ram_rdata) ? S_GATHER : S_EMIT;
					end
				end
				S_GATHER: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						bc_q <= bc_q + 4'd1;
						if (idx_q == count_q) begin
							if (bc_q == 4'd4) begin
								state_q <= S_EMIT;
							end
						end else if (bc_q == 4'd8) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						if (res_q.last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_GATHER;
							bc_q    <= '0;
							idx_q   <= idx_q + 6'd1;
							ph_q    <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: address walk, byte adder, record assembly
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd.go) begin
					count_q    <= cmd.count;
					sum_q      <= '0;
					chk_addr_q <= AW'(cmd.len - CHK_FROM_END);
					addr_q     <= AW'(POS_SUM0);
					res_q      <= mk_summary(cmd.status);
				end
			end
			S_SUM: begin
				if (ph_q) begin
					if (addr_q == chk_addr_q) begin
						addr_q <= AW'(POS_BODY);
						res_q  <= mk_summary(ST_CSUM);
					end else begin
						sum_q  <= sum_q + ram_rdata;
						addr_q <= addr_q + AW'(1);
					end
				end
			end
			S_GATHER: begin
				if (ph_q) begin
					shr_q  <= rec[63:0];
					addr_q <= addr_q + AW'(1);
					if (idx_q == count_q) begin
						// interval and frame number read, jump back for the distance
						if (bc_q == 4'd2) begin
							addr_q <= AW'(POS_DIST);
						end
						if (bc_q == 4'd4) begin
							res_q          <= mk_summary(ST_GOOD);
							res_q.interval <= smry[39:32];
							res_q.number   <= smry[31:16];
							res_q.nearest  <= smry[15:0];
						end
					end else if (bc_q == 4'd8) begin
						res_q          <= '0;
						res_q.kind     <= KIND_TARGET;
						res_q.status   <= ST_GOOD;
						res_q.index    <= idx_q[4:0];
						res_q.distance <= rec[71:56];
						res_q.velocity <= rec[55:40];
						res_q.angle_h  <= rec[39:24];
						res_q.angle_v  <= rec[23:8];
						res_q.snr      <= rec[7:0];
						res_q.last     <= 1'b0;
					end
				end
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
	end

endmodule

// ----- design/radar_target_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Radar target frame parser
// Takes one byte per transaction, hunts for the header and stores the frame
// in a buffer RAM; at the frame end a sequencer checks it and emits the results.
// A byte that neither closes a frame nor fails the count check leaves byte_ready high.
// Count or tail errors: one status summary, via the command register and emit state.
// Good frame: a checksum walk, then each target record and the summary; each byte
//   read has a read and a capture phase, and each result a hand-over, plus stalls.
// Reset clears the parser position and limit (32); the buffer is not cleared.
// ----------------------------------------------------------------------------
module radar_target_frame_parser #(
	parameter int MAX_TARGETS  = 32,
	parameter int BUFFER_DEPTH = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         rx_byte,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               kind,
	output logic [1:0]         status,
	output logic [4:0]         target_index,
	output logic [15:0]        target_distance,
	output logic signed [15:0] target_velocity,
	output logic signed [15:0] angle_horizontal,
	output logic signed [15:0] angle_vertical,
	output logic [7:0]         signal_to_noise,
	output logic [15:0]        nearest_distance,
	output logic [7:0]         frame_interval,
	output logic [15:0]        frame_number,
	output logic               last
);

	import rtfp_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [7:0] MAX_T = 8'(MAX_TARGETS);

	logic [CNT_W-1:0] limit_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] len_q;
	logic [7:0]       prev_q;
	rtfp_cmd_t        cmd_q;

	logic [7:0]       lim;
	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] len_new;
	logic             byte_fire;
	logic             ram_we;
	logic             seq_busy;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;
	rtfp_res_t        res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
			limit_q <= pwdata[CNT_W-1:0];
		end
	end

	assign lim       = ({2'b00, limit_q} > MAX_T) ? MAX_T : {2'b00, limit_q};
	assign pos_nxt   = pos_q + 9'd1;
	assign len_new   = LEN_BASE + {rx_byte[CNT_W-1:0], 3'b000} + POS_W'(rx_byte[CNT_W-1:0]);
	assign byte_ready = !seq_busy && !cmd_q.go;
	assign byte_fire = byte_valid && byte_ready;

	always_comb begin
		case (pos_q)
			9'd0:    ram_we = byte_fire && (rx_byte == HEAD0);
			9'd1:    ram_we = byte_fire && (rx_byte == HEAD1);
			default: ram_we = byte_fire;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
		end else begin
			cmd_q.go <= 1'b0;
			if (byte_fire) begin
				if (pos_q == 9'd0) begin
					if (rx_byte == HEAD0) begin
						pos_q <= 9'd1;
					end
				end else if (pos_q == 9'd1) begin
					// restart the hunt on a wrong second header byte
					pos_q <= (rx_byte == HEAD1) ? 9'd2 : 9'd0;
				end else if (pos_q < POS_BODY) begin
					pos_q <= pos_nxt;
					if (pos_q == POS_COUNT) begin
						if (rx_byte > lim) begin
							pos_q        <= '0;
							cmd_q.go     <= 1'b1;
							cmd_q.check  <= 1'b0;
							cmd_q.status <= ST_COUNT;
						end else begin
							count_q <= rx_byte[CNT_W-1:0];
							len_q   <= len_new;
						end
					end
				end else begin
					pos_q <= pos_nxt;
					if (pos_nxt >= len_q) begin
						pos_q       <= '0;
						cmd_q.go    <= 1'b1;
						cmd_q.count <= count_q;
						cmd_q.len   <= len_q;
						if ((prev_q != TAIL0) || (rx_byte != TAIL1)) begin
							cmd_q.check  <= 1'b0;
							cmd_q.status <= ST_TAIL;
						end else begin
							cmd_q.check  <= 1'b1;
							cmd_q.status <= ST_GOOD;
						end
					end
				end
			end
		end
	end

	// hold the previous byte for the tail check
	always_ff @(posedge clk) begin
		if (byte_fire) begin
			prev_q <= rx_byte;
		end
	end

	rtfp_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(pos_q)),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rtfp_seq #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_q),
		.busy      (seq_busy),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res       (res),
		.res_valid (result_valid),
		.res_ready (result_ready)
	);

	assign kind             = res.kind;
	assign status           = res.status;
	assign target_index     = res.index;
	assign target_distance  = res.distance;
	assign target_velocity  = $signed(res.velocity);
	assign angle_horizontal = $signed(res.angle_h);
	assign angle_vertical   = $signed(res.angle_v);
	assign signal_to_noise  = res.snr;
	assign nearest_distance = res.nearest;
	assign frame_interval   = res.interval;
	assign frame_number     = res.number;
	assign last             = res.last;

endmodule

// ----- design/rtfp_checker.sv -----
// ----------------------------------------------------------------------------
// Radar target frame parser checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic       kind,
	input logic [1:0] status,
	input logic       last
);

	import rtfp_pkg::*;

	`RTFP_ASSERT(a_res_hold, clk, arst_n, result_valid && !result_ready |=> result_valid, "result dropped while stalled")
	`RTFP_NEVER(a_no_overlap, clk, arst_n, byte_ready && result_valid, "byte taken while a result is pending")
	`RTFP_ASSERT(a_target_mid, clk, arst_n, result_valid && (kind == KIND_TARGET) |-> !last && (status == ST_GOOD), "target record marked last or bad")
	`RTFP_ASSERT(a_summary_last, clk, arst_n, result_valid && (kind == KIND_SUMMARY) |-> last, "summary not marked last")

endmodule

bind radar_target_frame_parser rtfp_checker u_rtfp_checker (.*);
